// ----- hw/rtl/two_class_ratio_merge_queue_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-class ratio merge queue.
// Every macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_RATIO_MERGE_QUEUE_UNIT_ASSERT_SVH
`define TWO_CLASS_RATIO_MERGE_QUEUE_UNIT_ASSERT_SVH

// The expression holds at every clock edge out of reset.
`define TRMQ_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("trmq: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define TRMQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trmq: same-cycle implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define TRMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trmq: next-cycle implication violated");

`endif

// ----- hw/rtl/trmq_pkg.sv -----
// ----------------------------------------------------------------------------
// trmq_pkg
// Types and constants shared by the two-class ratio merge queue.
// ----------------------------------------------------------------------------
`default_nettype none

package trmq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int ID_W            = 16;
	localparam int PASS_W          = 8;
	localparam int RATIO_W         = 8;
	localparam int STATUS_W        = 2;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd4;
	localparam logic [RATIO_W-1:0] SERVED_MAX  = 8'hFF;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   item_id;
		logic              is_premium;
		logic [PASS_W-1:0] passes_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_id;
		logic                from_priority;
		logic [PASS_W-1:0]   passes_left;
	} rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/trmq_ram.sv -----
// ----------------------------------------------------------------------------
// trmq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module trmq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/two_class_ratio_merge_queue_unit.sv -----
// ----------------------------------------------------------------------------
// two_class_ratio_merge_queue_unit: enqueue and empty dequeue give their result in the cycle
// after the transfer, one per cycle unless the response stalls; a pop waits on the registered
// RAM read and the response register; the next request is taken once the read data is back.
// Reset clears pointers, fill counts and the service counter and sets the service ratio to 4;
// the RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_ratio_merge_queue_unit_assert.svh"

module two_class_ratio_merge_queue_unit
	import trmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [RATIO_W-1:0] cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;

	logic [AW-1:0]      reg_head_q, reg_tail_q, pri_head_q, pri_tail_q;
	logic [CW-1:0]      reg_cnt_q, pri_cnt_q;
	logic [RATIO_W-1:0] served_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               sel_pri_s1;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic              accept, rsp_free;
	logic              is_enq, is_deq, to_pri;
	logic              reg_has, pri_has, reg_full, pri_full;
	logic              serve_pri;
	logic              reg_we, pri_we, reg_re, pri_re;
	logic              load_now;
	rsp_t              rsp_now;
	logic [ID_W-1:0]   reg_rdata, pri_rdata;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !rsp_free;
	assign accept    = req_valid && !req_stall;

	assign is_enq   = (req.mode == MODE_ENQ);
	assign is_deq   = (req.mode == MODE_DEQ);
	assign to_pri   = req.is_premium && (req.passes_in != '0);
	assign reg_has  = (reg_cnt_q != '0);
	assign pri_has  = (pri_cnt_q != '0);
	assign reg_full = (reg_cnt_q == FULL_CNT);
	assign pri_full = (pri_cnt_q == FULL_CNT);

	// Priority wins once the regular quota is used up, or when nothing regular waits.
	assign serve_pri = pri_has && ((served_q >= ratio_q) || !reg_has);

	assign reg_we = accept && is_enq && !to_pri && !reg_full;
	assign pri_we = accept && is_enq && to_pri && !pri_full;
	assign reg_re = accept && is_deq && !serve_pri && reg_has;
	assign pri_re = accept && is_deq && serve_pri;

	// Results that need no RAM read are formed right at the transfer.
	always_comb begin
		rsp_now  = '0;
		load_now = accept && !(reg_re || pri_re);
		if (is_enq) begin
			rsp_now.from_priority = to_pri;
			rsp_now.passes_left   = req.passes_in;
			if (to_pri) begin
				if (pri_full) begin
					rsp_now.status = ST_FULL;
				end else begin
					rsp_now.passes_left = req.passes_in - PASS_W'(1);
				end
			end else if (reg_full) begin
				rsp_now.status = ST_FULL;
			end
		end else begin
			rsp_now.status = ST_EMPTY;
		end
	end

	trmq_ram #(
		.WIDTH (ID_W),
		.DEPTH (QUEUE_DEPTH)
	) u_reg_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_tail_q),
		.wdata (req.item_id),
		.re    (reg_re),
		.raddr (reg_head_q),
		.rdata (reg_rdata)
	);

	trmq_ram #(
		.WIDTH (ID_W),
		.DEPTH (QUEUE_DEPTH)
	) u_pri_ram (
		.clk   (clk),
		.we    (pri_we),
		.waddr (pri_tail_q),
		.wdata (req.item_id),
		.re    (pri_re),
		.raddr (pri_head_q),
		.rdata (pri_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			reg_head_q <= '0;
			reg_tail_q <= '0;
			reg_cnt_q  <= '0;
			pri_head_q <= '0;
			pri_tail_q <= '0;
			pri_cnt_q  <= '0;
			served_q   <= '0;
			ratio_q    <= RATIO_RESET;
			sel_pri_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ratio_q <= cfg_data;
			end
			if (reg_we) begin
				reg_tail_q <= (reg_tail_q == LAST_SLOT) ? '0 : reg_tail_q + AW'(1);
				reg_cnt_q  <= reg_cnt_q + CW'(1);
			end
			if (pri_we) begin
				pri_tail_q <= (pri_tail_q == LAST_SLOT) ? '0 : pri_tail_q + AW'(1);
				pri_cnt_q  <= pri_cnt_q + CW'(1);
			end
			if (reg_re) begin
				reg_head_q <= (reg_head_q == LAST_SLOT) ? '0 : reg_head_q + AW'(1);
				reg_cnt_q  <= reg_cnt_q - CW'(1);
				if (served_q != SERVED_MAX) begin
					served_q <= served_q + RATIO_W'(1);
				end
			end
			if (pri_re) begin
				pri_head_q <= (pri_head_q == LAST_SLOT) ? '0 : pri_head_q + AW'(1);
				pri_cnt_q  <= pri_cnt_q - CW'(1);
				served_q   <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (reg_re || pri_re) begin
						state_q    <= S_READ;
						sel_pri_s1 <= pri_re;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_now || state_q == S_READ) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_now) begin
			rsp_q <= rsp_now;
		end else if (state_q == S_READ) begin
			rsp_q.status        <= ST_OK;
			rsp_q.out_id        <= sel_pri_s1 ? pri_rdata : reg_rdata;
			rsp_q.from_priority <= sel_pri_s1;
			rsp_q.passes_left   <= '0;
		end
	end

	`TRMQ_ASSERT_ALWAYS(a_reg_cnt_bound, reg_cnt_q <= FULL_CNT)
	`TRMQ_ASSERT_ALWAYS(a_pri_cnt_bound, pri_cnt_q <= FULL_CNT)
	`TRMQ_ASSERT_SAME(a_read_slot_free, state_q == S_READ, !rsp_valid_q && req_stall)
	`TRMQ_ASSERT_NEXT(a_read_delivers, state_q == S_READ, rsp_valid_q)
	`TRMQ_ASSERT_SAME(a_reg_empty_ptrs, reg_cnt_q == '0, reg_head_q == reg_tail_q)

endmodule

`default_nettype wire
